// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== hdl/shamh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Payload types, command struct, round constants and SHA-256 helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package shamh_pkg;

   localparam int BLOCK_BITS = 512;
   localparam int WORD_BITS  = 32;
   localparam int HASH_WORDS = 8;
   localparam int ROUNDS     = 64;

   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] BITS_PER_BYTE_SHIFT = 6'd3;

   // Operation codes of an input item.
   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Source of the byte shifted into the block window.
   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         shift_en;
      byte_sel_type shift_sel;
      logic [2:0]   len_sel;
      logic         count_bits;
      logic         load_work;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         update_hash;
      logic         init_hash;
      logic [2:0]   out_sel;
   } cmd_type;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_INIT [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/shamh_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block window with sliding message schedule, round logic, hash words and
// message bit counter.
// ----------------------------------------------------------------------------
`default_nettype none

module shamh_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire shamh_pkg::cmd_type cmd,
   input  wire logic [7:0]        data_byte,
   output logic [31:0]            digest_word
);
   import shamh_pkg::*;

   logic [BLOCK_BITS-1:0] window_ff, window_in;
   logic [31:0]           work_ff [HASH_WORDS];
   logic [31:0]           work_in [HASH_WORDS];
   logic [31:0]           hash_ff [HASH_WORDS];
   logic [31:0]           hash_in [HASH_WORDS];
   logic [63:0]           bits_ff, bits_in;

   logic [63:0] bits_shifted;
   logic [7:0]  len_byte;
   logic [7:0]  shift_byte;
   logic [31:0] w_cur, w_next, t1, t2;

   // Length bytes go out most significant first.
   assign bits_shifted = bits_ff >> ({3'b000, ~cmd.len_sel} << BITS_PER_BYTE_SHIFT);
   assign len_byte     = bits_shifted[7:0];

   // Byte that enters the block window.
   always_comb begin
      unique case (cmd.shift_sel)
         SEL_DATA: shift_byte = data_byte;
         SEL_PAD:  shift_byte = PAD_BYTE;
         SEL_ZERO: shift_byte = 8'h00;
         SEL_LEN:  shift_byte = len_byte;
         default:  shift_byte = 8'h00;
      endcase
   end

   // The top word of the window is the schedule word of the current round.
   assign w_cur  = window_ff[BLOCK_BITS-1 -: 32];
   assign w_next = small_sigma1(window_ff[32 +: 32]) + window_ff[32*6 +: 32]
                 + small_sigma0(window_ff[BLOCK_BITS-33 -: 32]) + w_cur;

   // One compression round.
   assign t1 = work_ff[7] + big_sigma1(work_ff[4]) + choose(work_ff[4], work_ff[5], work_ff[6])
             + ROUND_K[cmd.round_idx] + w_cur;
   assign t2 = big_sigma0(work_ff[0]) + majority(work_ff[0], work_ff[1], work_ff[2]);

   // Window: byte shift while filling, word shift while compressing.
   always_comb begin
      window_in = window_ff;
      if (cmd.shift_en) begin
         window_in = {window_ff[BLOCK_BITS-9:0], shift_byte};
      end else if (cmd.round_en) begin
         window_in = {window_ff[BLOCK_BITS-33:0], w_next};
      end
   end

   // Working variables.
   always_comb begin
      work_in = work_ff;
      if (cmd.load_work) begin
         work_in = hash_ff;
      end else if (cmd.round_en) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   // Hash words and message bit count.
   always_comb begin
      hash_in = hash_ff;
      bits_in = bits_ff;
      if (cmd.init_hash) begin
         hash_in = HASH_INIT;
         bits_in = '0;
      end else begin
         if (cmd.update_hash) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
         end
         if (cmd.count_bits) begin
            bits_in = {bits_ff[63:3] + 61'd1, 3'b000};
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      work_ff   <= work_in;
      if (reset) begin
         hash_ff <= HASH_INIT;
         bits_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         bits_ff <= bits_in;
      end
   end

   assign digest_word = hash_ff[cmd.out_sel];

endmodule

`default_nettype wire

// ===== hdl/shamh_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorb, padding, the 64 rounds of each compression and the
// digest output, and drives both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shamh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_op,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              word_index,
   output logic                    last_word,
   output shamh_pkg::cmd_type      cmd
);
   import shamh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_PADLEN,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   state_type  after_ff, after_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      fill_in       = fill_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.shift_sel = SEL_DATA;
      cmd.round_idx = round_ff;
      cmd.out_sel   = idx_ff;
      cmd.len_sel   = fill_ff[2:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ABSORB) begin
                  cmd.shift_en   = 1'b1;
                  cmd.count_bits = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == FILL_LAST) begin
                     cmd.load_work = 1'b1;
                     state_in      = ST_ROUND;
                     after_in      = ST_IDLE;
                  end
               end else begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SEL_PAD;
            fill_in       = fill_ff + 6'd1;
            state_in      = ST_PADZ;
            if (fill_ff == FILL_LAST) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               after_in      = ST_PADZ;
            end
         end
         ST_PADZ: begin
            if (fill_ff == FILL_LEN) begin
               state_in = ST_PADLEN;
            end else begin
               cmd.shift_en  = 1'b1;
               cmd.shift_sel = SEL_ZERO;
               fill_in       = fill_ff + 6'd1;
               if (fill_ff == FILL_LAST) begin
                  cmd.load_work = 1'b1;
                  state_in      = ST_ROUND;
                  after_in      = ST_PADZ;
               end
            end
         end
         ST_PADLEN: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SEL_LEN;
            fill_in       = fill_ff + 6'd1;
            if (fill_ff == FILL_LAST) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               after_in      = ST_EMIT;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_hash = 1'b1;
            state_in        = after_ff;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  cmd.init_hash = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   // Handshake outputs follow the registered state only.
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign word_index = idx_ff;
   assign last_word  = (idx_ff == WORD_LAST);

   // The round counter rests at zero outside a compression.
   `ASSERT_AT(a_round_rest, clock, reset, (state_ff != ST_ROUND) |-> (round_ff == 6'd0))
   // The digest is only shown after the final block has wrapped the fill count.
   `ASSERT_AT(a_emit_fill, clock, reset, (state_ff == ST_EMIT) |-> (fill_ff == 6'd0))
   // Length bytes only fill the last eight positions of a block.
   `ASSERT_AT(a_len_pos, clock, reset, (state_ff == ST_PADLEN) |-> (fill_ff[5:3] == 3'b111))
   // Taking the last digest word returns the block to idle.
   `ASSERT_AT(a_emit_done, clock, reset,
      (rsp_valid && !rsp_stall && last_word) |=> (state_ff == ST_IDLE && idx_ff == 3'd0))

endmodule

`default_nettype wire

// ===== hdl/sha256_message_hasher.sv =====
// Absorb: one byte per cycle while idle; each 64th byte starts a compression (64 rounds and
// a hash update) that stalls the bytes. Finish: the 0x80 pad byte, zeros up to the length
// position, a step that ends the zero padding, the length bytes, one compression per full
// block (one or two), then eight result words at one word per cycle when not stalled.
// Rate is set by the single round unit, which the message bytes wait on during compression.
// Reset loads the initial hash values and clears the fill and bit counters; no clearing pass.
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streaming SHA-256 of a byte message with digest output as eight words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire shamh_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output shamh_pkg::rsp_type      rsp_data
);
   import shamh_pkg::*;

   cmd_type     cmd;
   logic [2:0]  word_index;
   logic        last_word;
   logic [31:0] digest_word;

   shamh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_data.op),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .word_index (word_index),
      .last_word  (last_word),
      .cmd        (cmd)
   );

   shamh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data.data_byte),
      .digest_word (digest_word)
   );

   // Result item assembly.
   always_comb begin
      rsp_data.digest_word = digest_word;
      rsp_data.word_index  = word_index;
      rsp_data.last_word   = last_word;
   end

endmodule

`default_nettype wire

// ===== tb/sha256_message_hasher_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Watches both channels of the hasher, keeps its own SHA-256 state, predicts
// the eight digest words of each finished message and compares every result.
// ----------------------------------------------------------------------------

module sha256_message_hasher_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  shamh_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  shamh_pkg::rsp_type  rsp_data,
   output int                  fail_count,
   output int                  pending_count
);

   // Round constants of the compression function.
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Predicted hasher state.
   logic [31:0] chain_words [8];
   logic [7:0]  block_buf [64];
   logic [5:0]  buf_fill;
   logic [63:0] msg_bit_count;

   // Digest words still to come from the block, oldest first.
   shamh_pkg::rsp_type want_buf [16];
   int                 want_wr;
   int                 want_rd;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One 64-round compression of the block buffer into the chaining words.
   task automatic compress_buffer();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++)
         v[i] = chain_words[i];
      for (int t = 0; t < 64; t++) begin
         s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
         t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
         s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
         t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain_words[i] = chain_words[i] + v[i];
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++)
         chain_words[i] = SHA_IV[i];
      buf_fill = '0;
      msg_bit_count = '0;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      block_buf[buf_fill] = b;
      msg_bit_count = msg_bit_count + 64'd8;
      buf_fill = buf_fill + 6'd1;
      if (buf_fill == 6'd0)
         compress_buffer();
   endtask

   // Pad the message, run the last one or two compressions and queue the digest.
   task automatic finish_message();
      int pos;
      shamh_pkg::rsp_type word;
      pos = buf_fill;
      block_buf[pos] = 8'h80;
      pos = pos + 1;
      // No room left for the length: pad this block out and start another.
      if (pos > 56) begin
         while (pos < 64) begin
            block_buf[pos] = 8'h00;
            pos = pos + 1;
         end
         compress_buffer();
         pos = 0;
      end
      while (pos < 56) begin
         block_buf[pos] = 8'h00;
         pos = pos + 1;
      end
      for (int i = 0; i < 8; i++)
         block_buf[56+i] = msg_bit_count[63-8*i -: 8];
      compress_buffer();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = chain_words[i];
         word.word_index  = 3'(i);
         word.last_word   = (i == 7);
         want_buf[want_wr % 16] = word;
         want_wr = want_wr + 1;
      end
      restart_message();
   endtask

   // Track accepted items on both channels.
   always @(posedge clock) begin
      shamh_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         restart_message();
         want_wr = 0;
         want_rd = 0;
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.op == shamh_pkg::OP_FINISH)
               finish_message();
            else
               absorb_byte(req_data.data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (want_wr == want_rd) begin
               $error("unexpected result item: digest_word %h word_index %0d last_word %0d",
                      rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               errs = errs + 1;
            end else begin
               want = want_buf[want_rd % 16];
               want_rd = want_rd + 1;
               if (rsp_data.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want.digest_word, rsp_data.digest_word);
                  errs = errs + 1;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, actual %0d",
                         want.word_index, rsp_data.word_index);
                  errs = errs + 1;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %0d, actual %0d",
                         want.last_word, rsp_data.last_word);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= want_wr - want_rd;
   end

endmodule

// ===== tb/sha256_message_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds directed and random byte messages, each closed by a finish item, with
// random idling on both sides and one long result hold-off; the checker
// predicts and compares the digests.
// ----------------------------------------------------------------------------

module sha256_message_hasher_tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   shamh_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   shamh_pkg::rsp_type rsp_data;

   int fail_count;
   int pending_count;

   // Idle rates in percent and the current stimulus phase.
   int send_idle_pct = 10;
   int recv_idle_pct = 47;
   int stim_phase = 0;
   int sent_items = 0;
   int finished_msgs = 0;

   // Receiver hold-off state.
   int  hold_cycles = 0;
   logic hold_done = 1'b0;

   sha256_message_hasher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sha256_message_hasher_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stalls, and one long hold-off when the last phase begins.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (stim_phase == 2 && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cycles <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one item, idling first at random, and wait until it is taken.
   task automatic send_item(input logic op, input logic [7:0] b);
      shamh_pkg::req_type item;
      item.op = op;
      item.data_byte = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_items = sent_items + 1;
      if (op == shamh_pkg::OP_FINISH)
         finished_msgs = finished_msgs + 1;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_item(shamh_pkg::OP_ABSORB, 8'($urandom_range(255)));
      send_item(shamh_pkg::OP_FINISH, 8'($urandom_range(255)));
   endtask

   initial begin
      int len;
      int kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty message twice in a row; the finish byte is ignored.
      send_item(shamh_pkg::OP_FINISH, 8'hff);
      send_item(shamh_pkg::OP_FINISH, 8'h00);
      // The classic three-letter message.
      send_item(shamh_pkg::OP_ABSORB, 8'h61);
      send_item(shamh_pkg::OP_ABSORB, 8'h62);
      send_item(shamh_pkg::OP_ABSORB, 8'h63);
      send_item(shamh_pkg::OP_FINISH, 8'h5a);
      // Extreme byte values.
      send_item(shamh_pkg::OP_ABSORB, 8'h00);
      send_item(shamh_pkg::OP_ABSORB, 8'hff);
      send_item(shamh_pkg::OP_ABSORB, 8'h80);
      send_item(shamh_pkg::OP_ABSORB, 8'h7f);
      send_item(shamh_pkg::OP_ABSORB, 8'h01);
      send_item(shamh_pkg::OP_FINISH, 8'haa);

      // Random messages; lengths cluster around the block and padding boundaries.
      while (sent_items < 260 || finished_msgs < 14) begin
         if (sent_items > 180) begin
            stim_phase = 2;
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent_items > 96) begin
            stim_phase = 1;
            send_idle_pct = 47;
            recv_idle_pct = 10;
         end
         kind = $urandom_range(9);
         if (kind < 4)
            len = $urandom_range(4);
         else if (kind < 7)
            len = $urandom_range(72, 52);
         else if (kind < 8)
            len = $urandom_range(136, 118);
         else
            len = $urandom_range(40);
         // Keep the total item count close to the planned amount.
         if (len > 259 - sent_items)
            len = (sent_items < 259) ? 259 - sent_items : 0;
         send_message(len);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      // Drain the digests, then allow for any stray results.
      while (pending_count != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== sha256_message_hasher.f =====
+incdir+hdl
hdl/shamh_pkg.sv
hdl/shamh_datapath.sv
hdl/shamh_ctrl.sv
hdl/sha256_message_hasher.sv
tb/sha256_message_hasher_checker.sv
tb/sha256_message_hasher_tb.sv
